>>> hdl/cipe_pkg.sv
// ----------------------------------------------------------------------------
// cipe_pkg: shared types and constants of the checked integer plan executor
// Word layouts, action/opcode/status codes and sequencer states.
// ----------------------------------------------------------------------------
package cipe_pkg;

  localparam int DefPlanSteps = 64;
  localparam int DefArgSlots  = 8;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_EXEC   = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;
  localparam logic [1:0] ACT_NOP    = 2'd3;

  localparam logic [3:0] OP_ARG  = 4'd0;
  localparam logic [3:0] OP_IMM  = 4'd1;
  localparam logic [3:0] OP_ADD  = 4'd2;
  localparam logic [3:0] OP_SUB  = 4'd3;
  localparam logic [3:0] OP_MUL  = 4'd4;
  localparam logic [3:0] OP_MOD  = 4'd5;
  localparam logic [3:0] OP_NEG  = 4'd6;
  localparam logic [3:0] OP_LT   = 4'd7;
  localparam logic [3:0] OP_LE   = 4'd8;
  localparam logic [3:0] OP_GT   = 4'd9;
  localparam logic [3:0] OP_GE   = 4'd10;
  localparam logic [3:0] OP_COPY = 4'd11;
  localparam logic [3:0] OP_RSV  = 4'd12;

  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_RESERVE = 3'd1;
  localparam logic [2:0] ST_FAULT   = 3'd2;
  localparam logic [2:0] ST_FINAL   = 3'd3;
  localparam logic [2:0] ST_SKIP    = 3'd4;

  localparam logic [63:0] MIN_S64 = {1'b1, 63'd0};

  typedef struct packed {
    logic [1:0]         action;
    logic [3:0]         opcode;
    logic [5:0]         lhs_index;
    logic               lhs_present;
    logic [5:0]         rhs_index;
    logic               rhs_present;
    logic signed [63:0] immediate;
    logic [2:0]         arg_slot;
    logic signed [63:0] arg_value;
    logic [5:0]         result_index;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [63:0] value;
    logic [5:0]         fault_step;
    logic signed [63:0] fault_left;
    logic signed [63:0] fault_right;
    logic [62:0]        reserve_count;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_A, S_RD_B, S_EXEC, S_MUL, S_DIV, S_FIN_RD, S_WRITE, S_OUT
  } seq_state_t;

  // Command to and reply from the shared multiply/divide unit.
  typedef struct packed {
    logic start;
    logic is_mod;
  } mdu_cmd_t;

  typedef struct packed {
    logic        done;
    logic        ovf;
    logic [63:0] result;
  } mdu_rsp_t;

endpackage

>>> hdl/cipe_mdu.sv
// ----------------------------------------------------------------------------
// cipe_mdu: iterative signed multiply and remainder unit
// Multiply: 32x32 partial products, one per cycle. Remainder: restoring
// division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cipe_mdu
  import cipe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  mdu_cmd_t    cmd,
  input  logic [63:0] op_a,
  input  logic [63:0] op_b,
  output mdu_rsp_t    rsp
);

  logic        busy_r, busy_nxt;
  logic        mod_r, mod_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic [63:0] ua_r, ua_nxt;
  logic [63:0] ub_r, ub_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] lo_r, lo_nxt;
  logic [63:0] hi_r, hi_nxt;
  logic        done_r, done_nxt;
  logic        ovf_r, ovf_nxt;
  logic [63:0] res_r, res_nxt;

  logic [63:0] pp;
  logic [31:0] pa, pb;
  logic [64:0] trial;
  logic [64:0] shl;
  logic [128:0] acc;
  logic [63:0]  limit;

  always_comb begin
    unique case (cnt_r[1:0])
      2'd0: begin pa = ua_r[31:0];  pb = ub_r[31:0];  end
      2'd1: begin pa = ua_r[31:0];  pb = ub_r[63:32]; end
      2'd2: begin pa = ua_r[63:32]; pb = ub_r[31:0];  end
      default: begin pa = ua_r[63:32]; pb = ub_r[63:32]; end
    endcase
    pp    = {32'd0, pa} * {32'd0, pb};
    shl   = {rem_r, lo_r[63]};
    trial = shl - {1'b0, ub_r};
    limit = neg_r ? MIN_S64 : ~MIN_S64;
  end

  always_comb begin
    busy_nxt = busy_r; mod_nxt = mod_r; cnt_nxt = cnt_r; neg_nxt = neg_r;
    ua_nxt = ua_r; ub_nxt = ub_r; rem_nxt = rem_r; lo_nxt = lo_r; hi_nxt = hi_r;
    done_nxt = 1'b0; ovf_nxt = ovf_r; res_nxt = res_r;
    acc = {1'b0, hi_r, lo_r};
    if (cmd.start) begin
      busy_nxt = 1'b1;
      mod_nxt  = cmd.is_mod;
      cnt_nxt  = '0;
      ua_nxt   = op_a[63] ? 64'd0 - op_a : op_a;
      ub_nxt   = op_b[63] ? 64'd0 - op_b : op_b;
      neg_nxt  = cmd.is_mod ? op_a[63] : (op_a[63] ^ op_b[63]);
      rem_nxt  = '0;
      lo_nxt   = cmd.is_mod ? (op_a[63] ? 64'd0 - op_a : op_a) : 64'd0;
      hi_nxt   = '0;
    end else if (busy_r) begin
      if (!mod_r) begin
        unique case (cnt_r[1:0])
          2'd0: acc = acc + {65'd0, pp};
          2'd1, 2'd2: acc = acc + {33'd0, pp, 32'd0};
          default: acc = acc + {1'b0, pp, 64'd0};
        endcase
        {hi_nxt, lo_nxt} = acc[127:0];
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r[1:0] == 2'd3) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
          ovf_nxt  = (acc[127:64] != 64'd0) || (acc[63:0] > limit);
          res_nxt  = neg_r ? 64'd0 - acc[63:0] : acc[63:0];
        end
      end else begin
        lo_nxt = {lo_r[62:0], 1'b0};
        if (!trial[64]) rem_nxt = trial[63:0];
        else rem_nxt = shl[63:0];
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
          ovf_nxt  = 1'b0;
          res_nxt  = neg_r ? 64'd0 - rem_nxt : rem_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    mod_r <= mod_nxt; cnt_r <= cnt_nxt; neg_r <= neg_nxt; ua_r <= ua_nxt;
    ub_r <= ub_nxt; rem_r <= rem_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt;
    ovf_r <= ovf_nxt; res_r <= res_nxt;
  end

  assign rsp = '{done: done_r, ovf: ovf_r, result: res_r};

endmodule

>>> hdl/checked_int_plan_executor.sv
// Loads and no-ops go straight to the output stage; a finish first reads its result
// step; instructions read both operands, and mul and mod may use the shared unit.
// Throughput: one word at a time; in_stall is high from acceptance until the
// result word is taken. Reset (rst_n low, synchronous) clears the step counter,
// fault record and argument valid bits; steps at or above the counter read zero.
// ----------------------------------------------------------------------------
// checked_int_plan_executor: top level
// Sequencer, value/argument stores and fault record around a shared
// multiply/remainder unit.
// ----------------------------------------------------------------------------
module checked_int_plan_executor
  import cipe_pkg::*;
#(
  parameter int PLAN_STEPS = DefPlanSteps,
  parameter int ARG_SLOTS  = DefArgSlots
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int SW = (PLAN_STEPS > 1) ? $clog2(PLAN_STEPS) : 1;
  localparam int AW = (ARG_SLOTS > 1) ? $clog2(ARG_SLOTS) : 1;
  localparam int CW = $clog2(PLAN_STEPS + 1);

  // The value store is a memory with one write and one registered read port.
  logic [63:0] vmem [PLAN_STEPS];
  logic [63:0] vrd_r;
  logic [SW-1:0] vaddr;
  logic          vwe;
  logic [63:0]   vwdata;

  logic [63:0] amem [ARG_SLOTS];
  logic [ARG_SLOTS-1:0] aval_r;

  seq_state_t state_r, state_nxt;
  in_word_t   item_r;
  logic [CW-1:0] step_r, step_nxt;
  logic       flt_r, flt_nxt;
  logic [5:0] fstep_r, fstep_nxt;
  logic [63:0] fl_r, fl_nxt, fr_r, fr_nxt;
  logic [63:0] a_r, a_nxt, b_r, b_nxt;
  logic [63:0] res_r, res_nxt;
  logic        ok_r, ok_nxt;
  out_word_t   out_r, out_nxt;
  logic        ovld_r, ovld_nxt;
  mdu_cmd_t    mcmd;
  mdu_rsp_t    mrsp;

  logic a_live, b_live, r_live;
  logic [63:0] sum, dif, argv;
  logic signed [63:0] sa, sb;
  logic [AW-1:0] slot_w;

  cipe_mdu u_mdu (.clk(clk), .rst_n(rst_n), .cmd(mcmd), .op_a(a_r), .op_b(b_r),
                  .rsp(mrsp));

  assign a_live = item_r.lhs_present && ({{(32-CW){1'b0}}, step_r} > 32'(item_r.lhs_index))
                  && (32'(item_r.lhs_index) < PLAN_STEPS);
  assign b_live = item_r.rhs_present && ({{(32-CW){1'b0}}, step_r} > 32'(item_r.rhs_index))
                  && (32'(item_r.rhs_index) < PLAN_STEPS);
  assign r_live = ({{(32-CW){1'b0}}, step_r} > 32'(item_r.result_index))
                  && (32'(item_r.result_index) < PLAN_STEPS);
  assign sum = a_r + b_r;
  assign dif = a_r - b_r;
  assign sa  = a_r;
  assign sb  = b_r;
  assign slot_w = AW'(item_r.arg_slot);
  assign argv = (item_r.immediate >= 0 && item_r.immediate < 64'(ARG_SLOTS)
                 && aval_r[AW'(item_r.immediate)]) ? amem[AW'(item_r.immediate)] : 64'd0;

  // Next-state logic. A new word is taken only once the previous result word
  // has left the output register.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid && !ovld_r) begin
        unique case (in_data.action)
          ACT_LOAD, ACT_NOP: state_nxt = S_OUT;
          ACT_FINISH:        state_nxt = S_FIN_RD;
          default:           state_nxt = S_RD_A;
        endcase
      end
      S_RD_A:   state_nxt = S_RD_B;
      S_RD_B:   state_nxt = S_EXEC;
      S_EXEC: begin
        if (step_r >= CW'(PLAN_STEPS) || flt_r) state_nxt = S_WRITE;
        else if (item_r.opcode == OP_MUL || item_r.opcode == OP_MOD && b_r != 64'd0 &&
                 !(a_r == MIN_S64 && b_r == '1)) state_nxt = item_r.opcode == OP_MUL ?
                 S_MUL : S_DIV;
        else state_nxt = S_WRITE;
      end
      S_MUL, S_DIV: if (mrsp.done) state_nxt = S_WRITE;
      S_FIN_RD: state_nxt = S_WRITE;
      S_WRITE:  state_nxt = S_OUT;
      S_OUT:    if (!ovld_r || !out_stall) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Datapath and output logic. The left operand's read is issued at
  // acceptance and lands in S_RD_A; the right one lands in S_RD_B.
  always_comb begin
    step_nxt = step_r; flt_nxt = flt_r; fstep_nxt = fstep_r; fl_nxt = fl_r; fr_nxt = fr_r;
    a_nxt = a_r; b_nxt = b_r; res_nxt = res_r; ok_nxt = ok_r;
    out_nxt = out_r; ovld_nxt = ovld_r && out_stall;
    mcmd = '{start: 1'b0, is_mod: 1'b0};
    vwe = 1'b0; vwdata = res_r; vaddr = SW'(step_r);
    unique case (state_r)
      S_IDLE:   vaddr = SW'(in_data.lhs_index);
      S_RD_A: begin
        vaddr = SW'(item_r.rhs_index);
        a_nxt = a_live ? vrd_r : 64'd0;
      end
      S_RD_B:   b_nxt = b_live ? vrd_r : 64'd0;
      S_EXEC: begin
        ok_nxt = 1'b1; res_nxt = '0;
        if (item_r.opcode == OP_MUL) mcmd = '{start: 1'b1, is_mod: 1'b0};
        if (item_r.opcode == OP_MOD) mcmd = '{start: 1'b1, is_mod: 1'b1};
        unique case (item_r.opcode)
          OP_ARG:  res_nxt = argv;
          OP_IMM:  res_nxt = item_r.immediate;
          OP_ADD: begin
            res_nxt = sum;
            ok_nxt = !(~(a_r[63] ^ b_r[63]) & (a_r[63] ^ sum[63]));
          end
          OP_SUB: begin
            res_nxt = dif;
            ok_nxt = !((a_r[63] ^ b_r[63]) & (a_r[63] ^ dif[63]));
          end
          OP_MOD:  ok_nxt = b_r != 64'd0;
          OP_NEG: begin res_nxt = 64'd0 - a_r; ok_nxt = a_r != MIN_S64; end
          OP_LT:   res_nxt = 64'(sa < sb);
          OP_LE:   res_nxt = 64'(sa <= sb);
          OP_GT:   res_nxt = 64'(sa > sb);
          OP_GE:   res_nxt = 64'(sa >= sb);
          OP_COPY: res_nxt = a_r;
          default: res_nxt = '0;
        endcase
      end
      S_MUL, S_DIV: if (mrsp.done) begin
        res_nxt = mrsp.result;
        ok_nxt  = !mrsp.ovf;
      end
      S_FIN_RD: vaddr = SW'(item_r.result_index);
      S_WRITE: begin
        out_nxt = '0;
        if (item_r.action == ACT_FINISH) begin
          if (flt_r) begin
            out_nxt.status = ST_FAULT; out_nxt.fault_step = fstep_r;
            out_nxt.fault_left = fl_r; out_nxt.fault_right = fr_r;
          end else begin
            out_nxt.status = ST_FINAL;
            out_nxt.value = r_live ? vrd_r : 64'd0;
          end
          step_nxt = '0; flt_nxt = 1'b0; fstep_nxt = '0; fl_nxt = '0; fr_nxt = '0;
        end else if (step_r >= CW'(PLAN_STEPS) || flt_r) begin
          out_nxt.status = ST_SKIP; out_nxt.fault_step = fstep_r;
          out_nxt.fault_left = fl_r; out_nxt.fault_right = fr_r;
          if (step_r < CW'(PLAN_STEPS)) step_nxt = step_r + CW'(1);
        end else begin
          vwe = 1'b1;
          step_nxt = step_r + CW'(1);
          if (!ok_r) begin
            vwdata = '0;
            flt_nxt = 1'b1; fstep_nxt = 6'(step_r); fl_nxt = a_r; fr_nxt = b_r;
            out_nxt.status = ST_FAULT; out_nxt.fault_step = 6'(step_r);
            out_nxt.fault_left = a_r; out_nxt.fault_right = b_r;
          end else begin
            out_nxt.value = res_r;
            if (item_r.opcode == OP_RSV) begin
              out_nxt.status = ST_RESERVE;
              out_nxt.reserve_count = item_r.immediate[63] ? 63'd0 : item_r.immediate[62:0];
            end
          end
        end
      end
      S_OUT: if (!ovld_r || !out_stall) begin
        ovld_nxt = 1'b1;
        if (item_r.action == ACT_LOAD) begin
          out_nxt = '0;
          if (32'(item_r.arg_slot) < ARG_SLOTS) out_nxt.value = item_r.arg_value;
        end else if (item_r.action == ACT_NOP) out_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; step_r <= '0; flt_r <= 1'b0; fstep_r <= '0;
      fl_r <= '0; fr_r <= '0; ovld_r <= 1'b0; aval_r <= '0;
    end else begin
      state_r <= state_nxt; step_r <= step_nxt; flt_r <= flt_nxt; fstep_r <= fstep_nxt;
      fl_r <= fl_nxt; fr_r <= fr_nxt; ovld_r <= ovld_nxt;
      if (state_r == S_OUT && (!ovld_r || !out_stall) && item_r.action == ACT_LOAD &&
          32'(item_r.arg_slot) < ARG_SLOTS)
        aval_r[slot_w] <= 1'b1;
    end
    if (in_valid && !in_stall) item_r <= in_data;
    a_r <= a_nxt; b_r <= b_nxt; res_r <= res_nxt; ok_r <= ok_nxt; out_r <= out_nxt;
    if (state_r == S_OUT && (!ovld_r || !out_stall) && item_r.action == ACT_LOAD &&
        32'(item_r.arg_slot) < ARG_SLOTS)
      amem[slot_w] <= item_r.arg_value;
  end

  // Value store: only steps below the step counter are ever read as valid, and each
  // is written or skipped after a fault as the counter passes: nothing needs clearing.
  always_ff @(posedge clk) begin
    if (vwe) vmem[vaddr] <= vwdata;
    vrd_r <= vmem[vaddr];
  end

  assign in_stall  = (state_r != S_IDLE) || ovld_r;
  assign out_valid = ovld_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= CW'(PLAN_STEPS)) else $error("step counter beyond plan length");
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && !in_stall && state_r != S_IDLE)) else $error("accept while busy");
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !flt_r |-> (fl_r == 64'd0 && fr_r == 64'd0)) else $error("stale fault record");
`endif

endmodule

>>> sim/cipe_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cipe_checker: result predictor and scoreboard for the plan executor
// Watches both channels, predicts each result word from accepted input words
// and compares the result words field by field in order.
// ----------------------------------------------------------------------------
module cipe_checker
  import cipe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_data,
  output int        fail_count,
  output int        pending
);

  localparam logic [63:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;

  logic [63:0] step_vals [64];
  logic [63:0] arg_vals [8];
  int unsigned step_cnt;
  logic        faulted;
  logic [5:0]  flt_step;
  logic [63:0] flt_lhs, flt_rhs;
  out_word_t   expected_words [$];

  function automatic logic [63:0] read_step(logic [5:0] idx, logic present);
    if (!present || idx >= step_cnt) return 64'd0;
    return step_vals[idx];
  endfunction

  // Checked signed multiply using a 128-bit product.
  function automatic logic mul_fits(logic [63:0] a, logic [63:0] b, output logic [63:0] r);
    logic signed [127:0] p;
    p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
    r = p[63:0];
    return p[127:63] == {65{p[63]}};
  endfunction

  task automatic predict_word(in_word_t w);
    out_word_t   e;
    logic [63:0] a, b, r;
    logic        ok;
    e = '0;
    if (w.action == ACT_LOAD) begin
      arg_vals[w.arg_slot] = w.arg_value;
      e.value = w.arg_value;
    end else if (w.action == ACT_FINISH) begin
      if (faulted) begin
        e.status = ST_FAULT;
        e.fault_step = flt_step;
        e.fault_left = flt_lhs;
        e.fault_right = flt_rhs;
      end else begin
        e.status = ST_FINAL;
        e.value = read_step(w.result_index, 1'b1);
      end
      step_cnt = 0;
      faulted = 1'b0;
      flt_step = '0;
      flt_lhs = '0;
      flt_rhs = '0;
    end else if (w.action == ACT_EXEC) begin
      if (step_cnt >= 64 || faulted) begin
        e.status = ST_SKIP;
        e.fault_step = flt_step;
        e.fault_left = flt_lhs;
        e.fault_right = flt_rhs;
        if (step_cnt < 64) step_cnt++;
      end else begin
        a = read_step(w.lhs_index, w.lhs_present);
        b = read_step(w.rhs_index, w.rhs_present);
        r = '0;
        ok = 1'b1;
        case (w.opcode)
          OP_ARG: begin
            if (w.immediate >= 0 && w.immediate < 8) r = arg_vals[w.immediate[2:0]];
          end
          OP_IMM: r = w.immediate;
          OP_ADD: begin
            r = a + b;
            ok = !(~(a[63] ^ b[63]) & (a[63] ^ r[63]));
          end
          OP_SUB: begin
            r = a - b;
            ok = !((a[63] ^ b[63]) & (a[63] ^ r[63]));
          end
          OP_MUL: ok = mul_fits(a, b, r);
          OP_MOD: begin
            if (b == 0) ok = 1'b0;
            else if (a == MIN_S64 && b == '1) r = 0;
            else r = $signed(a) % $signed(b);
          end
          OP_NEG: begin
            if (a == MIN_S64) ok = 1'b0;
            else r = -a;
          end
          OP_LT: r = {63'd0, $signed(a) < $signed(b)};
          OP_LE: r = {63'd0, $signed(a) <= $signed(b)};
          OP_GT: r = {63'd0, $signed(a) > $signed(b)};
          OP_GE: r = {63'd0, $signed(a) >= $signed(b)};
          OP_COPY: r = a;
          OP_RSV: begin
            e.status = ST_RESERVE;
            e.reserve_count = w.immediate[63] ? '0 : w.immediate[62:0];
          end
          default: r = '0;
        endcase
        if (!ok) begin
          faulted = 1'b1;
          flt_step = step_cnt[5:0];
          flt_lhs = a;
          flt_rhs = b;
          step_vals[step_cnt] = '0;
          e = '0;
          e.status = ST_FAULT;
          e.fault_step = flt_step;
          e.fault_left = a;
          e.fault_right = b;
        end else begin
          step_vals[step_cnt] = r;
          e.value = r;
        end
        step_cnt++;
      end
    end
    expected_words.push_back(e);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch in %s: got %h, expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    step_cnt = 0;
    faulted = 1'b0;
    flt_step = '0;
    flt_lhs = '0;
    flt_rhs = '0;
    foreach (step_vals[i]) step_vals[i] = '0;
    foreach (arg_vals[i]) arg_vals[i] = '0;
  end

  assign pending = expected_words.size();

  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && in_valid && !in_stall) predict_word(in_data);
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $display("%0t result word with no expectation waiting", $realtime);
        fail_count++;
      end else begin
        e = expected_words.pop_front();
        if (out_data.status !== e.status)
          report_mismatch("status", 64'(out_data.status), 64'(e.status));
        if (out_data.value !== e.value)
          report_mismatch("value", out_data.value, e.value);
        if (out_data.fault_step !== e.fault_step)
          report_mismatch("fault_step", 64'(out_data.fault_step), 64'(e.fault_step));
        if (out_data.fault_left !== e.fault_left)
          report_mismatch("fault_left", out_data.fault_left, e.fault_left);
        if (out_data.fault_right !== e.fault_right)
          report_mismatch("fault_right", out_data.fault_right, e.fault_right);
        if (out_data.reserve_count !== e.reserve_count)
          report_mismatch("reserve_count", 64'(out_data.reserve_count),
                          64'(e.reserve_count));
      end
    end
  end

endmodule

>>> sim/tb_checked_int_plan_executor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_checked_int_plan_executor: stimulus and verdict for the plan executor
// Sends directed plans covering every opcode and several faults, then random plans,
// with bursty input pacing and patterned output stalls; a checker module
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_checked_int_plan_executor;
  import cipe_pkg::*;

  localparam int InBits = $bits(in_word_t);

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;
  int        fail_count;
  int        pending;

  // Position within the current plan, so random plans reach deep steps.
  int plan_len;
  int burst_left;

  checked_int_plan_executor dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  cipe_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // A 64-bit value biased toward the corners where checked arithmetic faults.
  function automatic logic [63:0] edgy_value();
    case ($urandom_range(0, 7))
      0: return MIN_S64;
      1: return ~MIN_S64;
      2: return '1;
      3: return 64'(int'($urandom_range(0, 20)) - 10);
      4: return {$urandom, $urandom};
      5: return {{33{$urandom_range(0, 1) == 1}}, 31'($urandom)};
      default: return 64'($urandom_range(0, 1000));
    endcase
  endfunction

  // Send one word: an optional random gap between bursts, then hold it until
  // the block accepts it. Only the falling edge changes inputs.
  task automatic send_word(in_word_t w);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_data <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_load(logic [2:0] slot, logic [63:0] v);
    in_word_t w;
    w = in_word_t'(InBits'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
    w.action = ACT_LOAD;
    w.arg_slot = slot;
    w.arg_value = v;
    send_word(w);
  endtask

  task automatic send_instr(logic [3:0] op, logic [5:0] li, logic lp, logic [5:0] ri,
                            logic rp, logic [63:0] imm);
    in_word_t w;
    w = in_word_t'(InBits'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
    w.action = ACT_EXEC;
    w.opcode = op;
    w.lhs_index = li;
    w.lhs_present = lp;
    w.rhs_index = ri;
    w.rhs_present = rp;
    w.immediate = imm;
    send_word(w);
    plan_len++;
  endtask

  task automatic send_finish(logic [5:0] idx);
    in_word_t w;
    w = in_word_t'(InBits'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
    w.action = ACT_FINISH;
    w.result_index = idx;
    send_word(w);
    plan_len = 0;
  endtask

  // One random word. Mostly well-formed instructions referring to earlier
  // steps, with loads, finishes, no-ops, unknown opcodes and stray indices mixed in.
  task automatic send_random();
    int          pick;
    in_word_t    w;
    logic [5:0]  li, ri;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_load(3'($urandom), edgy_value());
    end else if (pick < 12 || plan_len > $urandom_range(8, 80)) begin
      send_finish(plan_len > 0 && $urandom_range(0, 3) != 0 ?
                  6'($urandom_range(0, plan_len - 1)) : 6'($urandom));
    end else if (pick < 13) begin
      w = in_word_t'(InBits'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
      w.action = ACT_NOP;
      send_word(w);
    end else begin
      li = plan_len > 0 && $urandom_range(0, 7) != 0 ?
           6'($urandom_range(0, plan_len - 1)) : 6'($urandom);
      ri = plan_len > 0 && $urandom_range(0, 7) != 0 ?
           6'($urandom_range(0, plan_len - 1)) : 6'($urandom);
      send_instr($urandom_range(0, 9) == 0 ? 4'($urandom) : 4'($urandom_range(0, 12)),
                 li, $urandom_range(0, 9) != 0, ri, $urandom_range(0, 9) != 0,
                 $urandom_range(0, 2) == 0 ? 64'($urandom_range(0, 9)) : edgy_value());
    end
  endtask

  // The receiver stalls in runs whose pattern changes now and then,
  // including long stretches with no stall at all.
  initial begin
    int mode;
    out_stall = 1'b1;
    mode = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= $urandom_range(0, 3) == 0;
        2: out_stall <= $urandom_range(0, 1) == 0;
        default: out_stall <= $urandom_range(0, 9) != 0;
      endcase
    end
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int wait_cycles;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    plan_len = 0;
    burst_left = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed plan: every opcode, divide and overflow faults, skipping, plan full.
    send_load(3'd0, MIN_S64);
    send_load(3'd7, ~MIN_S64);
    send_instr(OP_ARG, 6'd0, 1'b0, 6'd0, 1'b0, 64'd0);     // step 0 = minimum value
    send_instr(OP_ARG, 6'd0, 1'b0, 6'd0, 1'b0, 64'd7);     // step 1 = max
    send_instr(OP_IMM, 6'd0, 1'b0, 6'd0, 1'b0, '1);        // step 2 = -1
    send_instr(OP_MOD, 6'd0, 1'b1, 6'd2, 1'b1, '0);        // min mod -1 is zero
    send_instr(OP_MOD, 6'd1, 1'b1, 6'd2, 1'b0, '0);        // mod by absent operand
    send_finish(6'd1);
    send_instr(OP_IMM, 6'd0, 1'b0, 6'd0, 1'b0, -64'sd7);
    send_instr(OP_IMM, 6'd0, 1'b0, 6'd0, 1'b0, 64'sd3);
    send_instr(OP_MOD, 6'd0, 1'b1, 6'd1, 1'b1, '0);
    send_instr(OP_LT, 6'd0, 1'b1, 6'd1, 1'b1, '0);
    send_instr(OP_LE, 6'd0, 1'b1, 6'd0, 1'b1, '0);
    send_instr(OP_GT, 6'd0, 1'b1, 6'd1, 1'b1, '0);
    send_instr(OP_GE, 6'd1, 1'b1, 6'd0, 1'b1, '0);
    send_instr(OP_COPY, 6'd63, 1'b1, 6'd0, 1'b0, '0);      // not yet written: zero
    send_instr(OP_RSV, 6'd0, 1'b0, 6'd0, 1'b0, -64'sd5);
    send_instr(OP_RSV, 6'd0, 1'b0, 6'd0, 1'b0, ~MIN_S64);
    send_instr(4'd14, 6'd0, 1'b0, 6'd0, 1'b0, '1);
    send_instr(OP_MUL, 6'd0, 1'b1, 6'd1, 1'b1, '0);
    send_instr(OP_ARG, 6'd0, 1'b0, 6'd0, 1'b0, 64'd9);     // argument out of range
    send_instr(OP_SUB, 6'd0, 1'b1, 6'd1, 1'b1, '0);
    send_finish(6'd2);
    send_instr(OP_ARG, 6'd0, 1'b0, 6'd0, 1'b0, 64'd0);
    send_instr(OP_NEG, 6'd0, 1'b1, 6'd0, 1'b0, '0);        // negate minimum faults
    send_instr(OP_ADD, 6'd0, 1'b0, 6'd0, 1'b0, '0);        // skipped after fault
    send_finish(6'd0);
    repeat (66) send_instr(OP_ADD, 6'd0, 1'b0, 6'd0, 1'b0, '0);  // overrun plan
    send_finish(6'd63);

    // Hold off until the block has drained, then go random.
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 100000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (1850) send_random();
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 200000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (100) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/cipe_pkg.sv
hdl/cipe_mdu.sv
hdl/checked_int_plan_executor.sv
sim/cipe_checker.sv
sim/tb_checked_int_plan_executor.sv
